/* hw/rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true at a clock edge outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif
`endif

/* hw/rtl/ethtcp_pkg.sv */
// ----------------------------------------------------------------------------
// ethtcp_pkg
// Types and constants shared by the Ethernet/IPv4/TCP header parser.
// ----------------------------------------------------------------------------
package ethtcp_pkg;

    localparam logic [15:0] ETH_TYPE_IPV4       = 16'h0800;
    localparam logic [7:0]  IP_PROTO_TCP        = 8'd6;
    localparam logic [7:0]  PREVIEW_LIMIT_RESET = 8'd30;
    localparam logic [3:0]  MIN_HDR_WORDS       = 4'd5;
    localparam logic [7:0]  NON_PRINT_CHAR      = 8'h2E;
    localparam logic [7:0]  PRINT_LOW           = 8'h20;
    localparam logic [7:0]  PRINT_HIGH          = 8'h7E;
    localparam int          TDATA_W             = 224;

    typedef enum logic
    {
        KIND_HEADER  = 1'b0,
        KIND_PREVIEW = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t              kind;
        logic               last;
        logic [47:0]        dst_mac;
        logic [47:0]        src_mac;
        logic [31:0]        src_ip;
        logic [31:0]        dst_ip;
        logic [15:0]        src_port;
        logic [15:0]        dst_port;
        logic signed [16:0] payload_length;
        logic [7:0]         preview_char;
    } result_t;

    function automatic logic [7:0] preview_map(input logic [7:0] b);
        if (b >= PRINT_LOW && b <= PRINT_HIGH)
        begin
            return b;
        end
        return NON_PRINT_CHAR;
    endfunction

endpackage

/* hw/rtl/ethtcp_in_reg.sv */
// ----------------------------------------------------------------------------
// ethtcp_in_reg
// Input register: holds one frame byte until the parser step consumes it.
// ----------------------------------------------------------------------------
module ethtcp_in_reg
    import ethtcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // frame_end
    input  logic       out_free,
    output logic       step_en,
    output logic [7:0] in_byte,
    output logic       in_last
);

    logic       valid_reg;
    logic [7:0] byte_reg;
    logic       last_reg;

    assign step_en       = valid_reg && out_free;
    assign s_axis_tready = !valid_reg || out_free;
    assign in_byte       = byte_reg;
    assign in_last       = last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_axis_tvalid && s_axis_tready)
        begin
            valid_reg <= 1'b1;
        end
        else if (step_en)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg <= s_axis_tdata;
            last_reg <= s_axis_tlast;
        end
    end

endmodule

/* hw/rtl/ethtcp_parse_core.sv */
// ----------------------------------------------------------------------------
// ethtcp_parse_core
// Frame state and the per-byte capture, filter and result logic.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ethtcp_parse_core
    import ethtcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       step_en,
    input  logic [7:0] data_byte,
    input  logic       frame_end,
    output logic       res_valid,
    output result_t    res
);

    logic [7:0]  preview_limit_reg;
    logic [15:0] byte_position_reg, byte_position_next;
    logic        frame_dropped_reg, frame_dropped_next;
    logic [47:0] dst_mac_reg, dst_mac_next;
    logic [47:0] src_mac_reg, src_mac_next;
    logic [15:0] ethertype_reg, ethertype_next;
    logic [3:0]  ip_hdr_words_reg, ip_hdr_words_next;
    logic [15:0] ip_total_len_reg, ip_total_len_next;
    logic [31:0] src_ip_reg, src_ip_next;
    logic [31:0] dst_ip_reg, dst_ip_next;
    logic [31:0] ports_reg, ports_next;
    logic [3:0]  tcp_hdr_words_reg, tcp_hdr_words_next;
    logic [7:0]  preview_remaining_reg, preview_remaining_next;

    logic [6:0]  tcp_start;
    logic [15:0] tcp_offset;
    logic [6:0]  hdr_bytes;
    logic [15:0] payload_diff;
    logic        payload_pos;
    logic [7:0]  preview_count;

    // Header arithmetic: both header lengths are at most 60 bytes each.
    assign tcp_start    = 7'd14 + {1'b0, ip_hdr_words_reg, 2'b00};
    assign tcp_offset   = byte_position_reg - {9'd0, tcp_start};
    assign hdr_bytes    = {1'b0, ip_hdr_words_reg, 2'b00} + {1'b0, tcp_hdr_words_reg, 2'b00};
    assign payload_diff = ip_total_len_reg - {9'd0, hdr_bytes};
    assign payload_pos  = ip_total_len_reg > {9'd0, hdr_bytes};

    always_comb
    begin
        preview_count = 8'd0;
        if (payload_pos)
        begin
            preview_count = (payload_diff < {8'd0, preview_limit_reg}) ?
                            payload_diff[7:0] : preview_limit_reg;
        end
    end

    always_comb
    begin
        byte_position_next     = byte_position_reg;
        frame_dropped_next     = frame_dropped_reg;
        dst_mac_next           = dst_mac_reg;
        src_mac_next           = src_mac_reg;
        ethertype_next         = ethertype_reg;
        ip_hdr_words_next      = ip_hdr_words_reg;
        ip_total_len_next      = ip_total_len_reg;
        src_ip_next            = src_ip_reg;
        dst_ip_next            = dst_ip_reg;
        ports_next             = ports_reg;
        tcp_hdr_words_next     = tcp_hdr_words_reg;
        preview_remaining_next = preview_remaining_reg;
        res_valid              = 1'b0;
        res                    = '0;

        if (!frame_dropped_reg)
        begin
            if (preview_remaining_reg != 8'd0)
            begin
                preview_remaining_next = preview_remaining_reg - 8'd1;
                res_valid              = 1'b1;
                res.kind               = KIND_PREVIEW;
                res.preview_char       = preview_map(data_byte);
                res.last               = (preview_remaining_reg == 8'd1);
            end
            else if (byte_position_reg < 16'd6)
            begin
                dst_mac_next = {dst_mac_reg[39:0], data_byte};
            end
            else if (byte_position_reg < 16'd12)
            begin
                src_mac_next = {src_mac_reg[39:0], data_byte};
            end
            else if (byte_position_reg < 16'd14)
            begin
                ethertype_next = {ethertype_reg[7:0], data_byte};
                if (byte_position_reg == 16'd13 && ethertype_next != ETH_TYPE_IPV4)
                begin
                    frame_dropped_next = 1'b1;
                end
            end
            else if (byte_position_reg < 16'd34)
            begin
                if (byte_position_reg == 16'd14)
                begin
                    ip_hdr_words_next = data_byte[3:0];
                    if (data_byte[3:0] < MIN_HDR_WORDS)
                    begin
                        frame_dropped_next = 1'b1;
                    end
                end
                else if (byte_position_reg == 16'd16 || byte_position_reg == 16'd17)
                begin
                    ip_total_len_next = {ip_total_len_reg[7:0], data_byte};
                end
                else if (byte_position_reg == 16'd23)
                begin
                    if (data_byte != IP_PROTO_TCP)
                    begin
                        frame_dropped_next = 1'b1;
                    end
                end
                else if (byte_position_reg >= 16'd26 && byte_position_reg < 16'd30)
                begin
                    src_ip_next = {src_ip_reg[23:0], data_byte};
                end
                else if (byte_position_reg >= 16'd30)
                begin
                    dst_ip_next = {dst_ip_reg[23:0], data_byte};
                end
            end
            else if (byte_position_reg >= {9'd0, tcp_start})
            begin
                if (tcp_offset < 16'd4)
                begin
                    ports_next = {ports_reg[23:0], data_byte};
                end
                if (tcp_offset == 16'd12)
                begin
                    tcp_hdr_words_next = data_byte[7:4];
                    if (data_byte[7:4] < MIN_HDR_WORDS)
                    begin
                        frame_dropped_next = 1'b1;
                    end
                end
                // The last TCP header byte closes the header record.
                if (!frame_dropped_next && tcp_offset > 16'd12 &&
                    (tcp_offset + 16'd1) == {10'd0, tcp_hdr_words_reg, 2'b00})
                begin
                    preview_remaining_next = preview_count;
                    res_valid              = 1'b1;
                    res.kind               = KIND_HEADER;
                    res.dst_mac            = dst_mac_reg;
                    res.src_mac            = src_mac_reg;
                    res.src_ip             = src_ip_reg;
                    res.dst_ip             = dst_ip_reg;
                    res.src_port           = ports_reg[31:16];
                    res.dst_port           = ports_reg[15:0];
                    res.payload_length     = {1'b0, ip_total_len_reg} - {10'd0, hdr_bytes};
                    res.last               = (preview_count == 8'd0);
                end
            end
        end

        if (byte_position_reg != 16'hFFFF)
        begin
            byte_position_next = byte_position_reg + 16'd1;
        end
        if (frame_end)
        begin
            byte_position_next     = 16'd0;
            frame_dropped_next     = 1'b0;
            preview_remaining_next = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            preview_limit_reg <= PREVIEW_LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            preview_limit_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_position_reg     <= '0;
            frame_dropped_reg     <= 1'b0;
            dst_mac_reg           <= '0;
            src_mac_reg           <= '0;
            ethertype_reg         <= '0;
            ip_hdr_words_reg      <= '0;
            ip_total_len_reg      <= '0;
            src_ip_reg            <= '0;
            dst_ip_reg            <= '0;
            ports_reg             <= '0;
            tcp_hdr_words_reg     <= '0;
            preview_remaining_reg <= '0;
        end
        else if (step_en)
        begin
            byte_position_reg     <= byte_position_next;
            frame_dropped_reg     <= frame_dropped_next;
            dst_mac_reg           <= dst_mac_next;
            src_mac_reg           <= src_mac_next;
            ethertype_reg         <= ethertype_next;
            ip_hdr_words_reg      <= ip_hdr_words_next;
            ip_total_len_reg      <= ip_total_len_next;
            src_ip_reg            <= src_ip_next;
            dst_ip_reg            <= dst_ip_next;
            ports_reg             <= ports_next;
            tcp_hdr_words_reg     <= tcp_hdr_words_next;
            preview_remaining_reg <= preview_remaining_next;
        end
    end

    `ASSERT_PROP(a_hdr_after_ip, clk, rst_n, step_en && res_valid && res.kind == KIND_HEADER |-> byte_position_reg >= 16'd34, "Header record before the end of the IP header")
    `ASSERT_PROP(a_preview_pending, clk, rst_n, step_en && res_valid && res.kind == KIND_PREVIEW |-> preview_remaining_reg != 8'd0, "Preview character with no preview pending")
    `ASSERT_PROP(a_frame_end_rearm, clk, rst_n, step_en && frame_end |=> byte_position_reg == 16'd0 && preview_remaining_reg == 8'd0 && !frame_dropped_reg, "Frame end did not re-arm the parser")
    `ASSERT_PROP(a_hdr_last_no_preview, clk, rst_n, step_en && res_valid && res.kind == KIND_HEADER && res.last |=> preview_remaining_reg == 8'd0, "Header marked last but preview follows")
    `ASSERT_NEVER(a_dropped_quiet, clk, rst_n, res_valid && frame_dropped_reg, "Result produced for a dropped frame")

endmodule

/* hw/rtl/ethtcp_out_reg.sv */
// ----------------------------------------------------------------------------
// ethtcp_out_reg
// Result register driving the master stream; packs the result fields.
// ----------------------------------------------------------------------------
module ethtcp_out_reg
    import ethtcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step_en,
    input  logic               res_valid,
    input  result_t            res,
    output logic               out_free,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,
    output logic               m_axis_tlast
);

    logic    valid_reg;
    result_t res_reg;

    assign out_free      = !valid_reg || m_axis_tready;
    assign m_axis_tvalid = valid_reg;
    assign m_axis_tuser  = res_reg.kind;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tdata  = {7'd0, res_reg.preview_char, res_reg.payload_length,
                            res_reg.dst_port, res_reg.src_port, res_reg.dst_ip,
                            res_reg.src_ip, res_reg.src_mac, res_reg.dst_mac};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            valid_reg <= step_en && res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_en && res_valid)
        begin
            res_reg <= res;
        end
    end

endmodule

/* hw/rtl/eth_ipv4_tcp_header_parser_unit.sv */
// ----------------------------------------------------------------------------
// eth_ipv4_tcp_header_parser_unit
// Ethernet/IPv4/TCP header parser with payload preview, top level.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the slave stream, one byte per transaction, starting
// at the destination MAC; s_axis_tlast marks the final byte of a frame.
// Frames that are not IPv4 carrying TCP, or whose IP or TCP header length is
// below five words, produce nothing. For a kept frame, the transaction that
// carries the last TCP header byte yields a header record (tuser = 0), and
// each of the following payload bytes, up to the preview limit, yields one
// preview character (tuser = 1). tlast marks the final result of a frame; a
// frame that ends early simply stops producing results.
// The preview limit is written through cfg_wr_en/cfg_wr_data and resets to 30;
// write it only while the block is idle, which the block itself does not enforce.
// Timing: a byte is held in the input register and parsed from there, and its
// result is registered into the output register when the parse step advances.
// One byte is accepted every cycle while the receiver does not stall; the rate
// is set by the single parse step between the two registers.
// When the receiver stalls, the output register holds its result and the
// input register fills, after which s_axis_tready falls. Reset empties both
// registers and returns the parser to the start of a frame.
// ----------------------------------------------------------------------------
module eth_ipv4_tcp_header_parser_unit
    import ethtcp_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,    // [7:0] preview_limit
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,   // [7:0] data_byte
    input  logic               s_axis_tlast,   // frame_end
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // [47:0] dst_mac, [95:48] src_mac, [127:96] src_ip, [159:128] dst_ip,
    // [175:160] src_port, [191:176] dst_port, [208:192] payload_length,
    // [216:209] preview_char, [223:217] zero
    output logic [TDATA_W-1:0] m_axis_tdata,
    output logic               m_axis_tuser,   // kind
    output logic               m_axis_tlast    // last
);

    logic       out_free;
    logic       step_en;
    logic [7:0] in_byte;
    logic       in_last;
    logic       res_valid;
    result_t    res;

    // Input side: one byte of buffering ahead of the parse step.
    ethtcp_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .out_free      (out_free),
        .step_en       (step_en),
        .in_byte       (in_byte),
        .in_last       (in_last)
    );

    // The parse step advances the frame state only when the result register
    // can take whatever this byte produces.
    ethtcp_parse_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .step_en     (step_en),
        .data_byte   (in_byte),
        .frame_end   (in_last),
        .res_valid   (res_valid),
        .res         (res)
    );

    ethtcp_out_reg u_out_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .step_en       (step_en),
        .res_valid     (res_valid),
        .res           (res),
        .out_free      (out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule
